// ----- hdl/ctbc_pkg.sv -----
package ctbc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int CHAN_W  = 8;
   localparam int BOUND_W = 9;
   localparam int POS_W   = 11;
   localparam int SUM_W   = 44;
   localparam int CNT_W   = 23;

   // step counter of the serial divider, one step per dividend bit
   localparam int DIV_STEP_W = $clog2(SUM_W);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CNT_W;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HIGH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HITS   = 3'd6;

   localparam logic [BOUND_W-1:0] RST_BLUE_LOW   = 9'd0;
   localparam logic [BOUND_W-1:0] RST_BLUE_HIGH  = 9'd85;
   localparam logic [BOUND_W-1:0] RST_GREEN_LOW  = 9'd0;
   localparam logic [BOUND_W-1:0] RST_GREEN_HIGH = 9'd90;
   localparam logic [BOUND_W-1:0] RST_RED_LOW    = 9'd53;
   localparam logic [BOUND_W-1:0] RST_RED_HIGH   = 9'd256;
   localparam logic [CNT_W-1:0]   RST_MIN_HITS   = 23'd100;

   typedef struct packed {
      logic [BOUND_W-1:0] blue_low;
      logic [BOUND_W-1:0] blue_high;
      logic [BOUND_W-1:0] green_low;
      logic [BOUND_W-1:0] green_high;
      logic [BOUND_W-1:0] red_low;
      logic [BOUND_W-1:0] red_high;
      logic [CNT_W-1:0]   min_hits;
   } cfg_type;

   // totals of one finished frame
   typedef struct packed {
      logic [CNT_W-1:0] hit_count;
      logic [SUM_W-1:0] row_sum;
      logic [SUM_W-1:0] col_sum;
   } frame_sums_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_LOAD
   } back_state_type;

endpackage

// ----- hdl/ctbc_fifo.sv -----
module ctbc_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ctbc_pkg::frame_sums_type push_data,
   input  logic                    pop,
   output ctbc_pkg::frame_sums_type pop_data,
   output logic                    full,
   output logic                    empty
);
   import ctbc_pkg::*;

   frame_sums_type               mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]          count_ff, count_in;

   assign full     = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/ctbc_front.sv -----
module ctbc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // blue [7:0], green [15:8], red [23:16]
   input  logic [ctbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   // line_end
   input  logic                                req_tuser,
   input  ctbc_pkg::cfg_type                   cfg,
   input  logic                                fifo_full,
   output logic                                push,
   output ctbc_pkg::frame_sums_type            push_data
);
   import ctbc_pkg::*;

   logic [POS_W-1:0]  col_pos_ff, col_pos_in;
   logic [POS_W-1:0]  row_pos_ff, row_pos_in;
   logic [SUM_W-1:0]  col_sum_ff, col_sum_in;
   logic [SUM_W-1:0]  row_sum_ff, row_sum_in;
   logic [CNT_W-1:0]  hit_count_ff, hit_count_in;

   logic [BOUND_W-1:0] blue, green, red;
   logic               hit;
   logic               accept;
   logic [SUM_W:0]     col_sum_add, row_sum_add;
   logic [SUM_W-1:0]   col_sum_nx, row_sum_nx;
   logic [CNT_W-1:0]   hit_count_nx;

   assign blue  = {1'b0, req_tdata[CHAN_W-1:0]};
   assign green = {1'b0, req_tdata[2*CHAN_W-1:CHAN_W]};
   assign red   = {1'b0, req_tdata[3*CHAN_W-1:2*CHAN_W]};

   assign hit = (blue  > cfg.blue_low)  && (blue  < cfg.blue_high)  &&
                (green > cfg.green_low) && (green < cfg.green_high) &&
                (red   > cfg.red_low)   && (red   < cfg.red_high);

   // hold the pixel while the queue has no room for a frame total
   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;

   // saturating accumulate: a carry out pins the sum at all ones
   assign col_sum_add = {1'b0, col_sum_ff} + (SUM_W+1)'(col_pos_ff);
   assign row_sum_add = {1'b0, row_sum_ff} + (SUM_W+1)'(row_pos_ff);

   always_comb begin
      col_sum_nx   = col_sum_ff;
      row_sum_nx   = row_sum_ff;
      hit_count_nx = hit_count_ff;
      if (hit) begin
         col_sum_nx = col_sum_add[SUM_W] ? '1 : col_sum_add[SUM_W-1:0];
         row_sum_nx = row_sum_add[SUM_W] ? '1 : row_sum_add[SUM_W-1:0];
         if (hit_count_ff != '1) begin
            hit_count_nx = hit_count_ff + 1'b1;
         end
      end
   end

   assign push                = accept && req_tlast;
   assign push_data.col_sum   = col_sum_nx;
   assign push_data.row_sum   = row_sum_nx;
   assign push_data.hit_count = hit_count_nx;

   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      col_sum_in   = col_sum_ff;
      row_sum_in   = row_sum_ff;
      hit_count_in = hit_count_ff;
      if (accept) begin
         priority if (req_tlast) begin
            col_pos_in   = '0;
            row_pos_in   = '0;
            col_sum_in   = '0;
            row_sum_in   = '0;
            hit_count_in = '0;
         end else begin
            col_sum_in   = col_sum_nx;
            row_sum_in   = row_sum_nx;
            hit_count_in = hit_count_nx;
            if (req_tuser) begin
               col_pos_in = '0;
               if (row_pos_ff != POS_W'(MAX_HEIGHT-1)) begin
                  row_pos_in = row_pos_ff + 1'b1;
               end
            end else if (col_pos_ff != POS_W'(MAX_WIDTH-1)) begin
               col_pos_in = col_pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_sum_ff   <= '0;
         row_sum_ff   <= '0;
         hit_count_ff <= '0;
      end else begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         hit_count_ff <= hit_count_in;
      end
   end

endmodule

// ----- hdl/ctbc_div.sv -----
module ctbc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ctbc_pkg::SUM_W-1:0]    dividend,
   input  logic [ctbc_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [ctbc_pkg::POS_W-1:0]    quotient
);
   import ctbc_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        dvs_ff, dvs_in;
   logic [SUM_W-1:0]        dq_ff, dq_in;

   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;
   logic                ge;
   logic                last_step;

   // restoring division, one quotient bit per cycle, msb first;
   // dq shifts the dividend out and the quotient in
   assign trial     = {rem_ff, dq_ff[SUM_W-1]};
   assign diff      = trial - {1'b0, dvs_ff};
   assign ge        = (trial >= {1'b0, dvs_ff});
   assign last_step = (step_ff == DIV_STEP_W'(SUM_W-1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         dq_in   = {dq_ff[SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff[POS_W-1:0];

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dq_ff  <= dq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- hdl/ctbc_back.sv -----
module ctbc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fifo_empty,
   input  ctbc_pkg::frame_sums_type          pop_data,
   output logic                              pop,
   input  logic [ctbc_pkg::CNT_W-1:0]        min_hits,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // center_col [10:0], center_row [21:11], zero [23:22]
   output logic [ctbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found
   output logic                              rsp_tuser
);
   import ctbc_pkg::*;

   back_state_type     state_ff, state_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [POS_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_found_ff, rsp_found_in;

   logic               found_now;
   logic               div_start;
   logic               col_done, row_done;
   logic [POS_W-1:0]   col_quot, row_quot;
   logic               out_free;
   logic               load;

   assign found_now = (pop_data.hit_count > min_hits);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   ctbc_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pop_data.col_sum),
      .divisor  (pop_data.hit_count),
      .done     (col_done),
      .quotient (col_quot)
   );

   ctbc_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pop_data.row_sum),
      .divisor  (pop_data.hit_count),
      .done     (row_done),
      .quotient (row_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               state_in = found_now ? BK_DIV : BK_LOAD;
            end
         end
         BK_DIV: begin
            if (col_done && row_done) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop       = !fifo_empty;
            div_start = !fifo_empty && found_now;
         end
         BK_DIV: ;
         BK_LOAD: load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      found_in     = pop ? found_now : found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_found_in = rsp_found_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = found_ff ? col_quot : '0;
         rsp_row_in   = found_ff ? row_quot : '0;
         rsp_found_in = found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*POS_W){1'b0}}, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_found_ff;

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/color_threshold_blob_centroid_core.sv -----
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: blue, green, red; tuser: line_end;
//                                       tlast: frame_end
// rsp_      out  rsp_tvalid/rsp_tready  tdata: center_col, center_row; tuser: found
// csr_      in   csr_we                 csr_index, csr_wdata
//
// One pixel is taken per cycle while the frame queue (two frames) has room.
// A result leaves once the frame's last pixel has passed the queue and the 44-step
// radix-2 divider pair; frames with no detection skip the divide.
// Reset is synchronous; it loads the register defaults and clears all sums.
// rsp_tready low holds the result register, then the queue, then req_tready.
module color_threshold_blob_centroid_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // blue [7:0], green [15:8], red [23:16]
   input  logic [ctbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // frame_end
   input  logic                                req_tlast,
   // line_end
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // center_col [10:0], center_row [21:11], zero [23:22]
   output logic [ctbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [ctbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ctbc_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   frame_sums_type  push_data, pop_data;
   logic            push, pop, fifo_full, fifo_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLUE_LOW:   cfg_in.blue_low   = csr_wdata[BOUND_W-1:0];
            CSR_BLUE_HIGH:  cfg_in.blue_high  = csr_wdata[BOUND_W-1:0];
            CSR_GREEN_LOW:  cfg_in.green_low  = csr_wdata[BOUND_W-1:0];
            CSR_GREEN_HIGH: cfg_in.green_high = csr_wdata[BOUND_W-1:0];
            CSR_RED_LOW:    cfg_in.red_low    = csr_wdata[BOUND_W-1:0];
            CSR_RED_HIGH:   cfg_in.red_high   = csr_wdata[BOUND_W-1:0];
            CSR_MIN_HITS:   cfg_in.min_hits   = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blue_low   <= RST_BLUE_LOW;
         cfg_ff.blue_high  <= RST_BLUE_HIGH;
         cfg_ff.green_low  <= RST_GREEN_LOW;
         cfg_ff.green_high <= RST_GREEN_HIGH;
         cfg_ff.red_low    <= RST_RED_LOW;
         cfg_ff.red_high   <= RST_RED_HIGH;
         cfg_ff.min_hits   <= RST_MIN_HITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_data  (push_data)
   );

   ctbc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   ctbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .min_hits   (cfg_ff.min_hits),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
